// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, idle while reset is applied.
`define HPBC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("hpbc assertion failed");

// Concurrent check that also holds during reset.
`define HPBC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("hpbc assertion failed");

`endif

// ----- rtl/hpbc_pkg.sv -----
// Types, constants and helper functions of the hand pose symbol unit.
package hpbc_pkg;

	// Throttle: divide by 100 as multiply by ceil(2^22/100), then shift by 22
	localparam int unsigned DIV_SHIFT = 22;
	localparam logic [15:0] DIV_MUL = 16'd41944;
	localparam logic [6:0] THR_MAX = 7'd127;

	// Pitch thresholds on the negated Q3.12 angle, and the levels they give
	localparam logic signed [16:0] PITCH_T1 = 17'sd2212;
	localparam logic signed [16:0] PITCH_T2 = 17'sd4424;
	localparam logic signed [16:0] PITCH_T3 = 17'sd6636;
	localparam logic signed [16:0] PITCH_T4 = 17'sd8848;
	localparam logic signed [16:0] PITCH_T5 = 17'sd11060;
	localparam logic [6:0] PITCH_L1 = 7'd13;
	localparam logic [6:0] PITCH_L2 = 7'd38;
	localparam logic [6:0] PITCH_L3 = 7'd63;
	localparam logic [6:0] PITCH_L4 = 7'd89;
	localparam logic [6:0] PITCH_L5 = 7'd114;

	// Yaw dead band of +-1.0 rad and its levels
	localparam logic signed [15:0] YAW_LO = -16'sd4096;
	localparam logic signed [15:0] YAW_HI = 16'sd4096;
	localparam logic [6:0] YAW_MID = 7'd63;
	localparam logic [6:0] YAW_NEG = 7'd31;
	localparam logic [6:0] YAW_POS = 7'd94;

	// Scan order: 7 bits times 3 channels
	localparam int unsigned NUM_CH = 3;
	localparam int unsigned LVL_W = 7;
	localparam int unsigned SCAN_LEN = NUM_CH * LVL_W;

	typedef enum logic [1:0] {
		CH_THR = 2'd0,
		CH_PIT = 2'd1,
		CH_YAW = 2'd2
	} chan_t;

	// Symbol bases for a bit turning on and off
	localparam logic [6:0] THR_ON = 7'h52;  // 'R'
	localparam logic [6:0] THR_OFF = 7'h72; // 'r'
	localparam logic [6:0] PIT_ON = 7'h4A;  // 'J'
	localparam logic [6:0] PIT_OFF = 7'h6A; // 'j'
	localparam logic [6:0] YAW_ON = 7'h42;  // 'B'
	localparam logic [6:0] YAW_OFF = 7'h62; // 'b'

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul;
		logic upd;
		logic step;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic pend_empty;
	} dp_stat_t;

	// Symbol for channel ch, new bit value on, offset off = 6 - bit
	function automatic logic [6:0] sym_char(chan_t ch, logic on, logic [2:0] off);
		logic [6:0] base;
		case (ch)
			CH_THR: base = on ? THR_ON : THR_OFF;
			CH_PIT: base = on ? PIT_ON : PIT_OFF;
			CH_YAW: base = on ? YAW_ON : YAW_OFF;
			default: base = on ? THR_ON : THR_OFF;
		endcase
		return base + {4'd0, off};
	endfunction

endpackage

// ----- rtl/hpbc_dp.sv -----
// Datapath: frame registers, level update, change scan and output register.
module hpbc_dp import hpbc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic signed [15:0] palm_vertical_velocity,
	input  logic signed [15:0] palm_pitch,
	input  logic signed [15:0] palm_yaw,
	output logic               sym_valid,
	input  logic               sym_stall,
	output logic [6:0]         char_code,
	output logic               last
);

	logic signed [15:0] vel_q;
	logic signed [15:0] pitch_q;
	logic signed [15:0] yaw_q;
	logic [15:0]        vmag;
	logic [16:0]        vneg;
	logic [31:0]        prod_s1;
	logic               vneg_s1;
	logic [9:0]         quot;
	logic signed [10:0] squot;
	logic signed [10:0] tsum;
	logic signed [16:0] pneg;
	logic [6:0]         thr_q, pit_q, yawl_q;
	logic [6:0]         new_t, new_p, new_y;
	logic [6:0]         chg_t, chg_p, chg_y;
	logic [SCAN_LEN-1:0] pend_q, val_q;
	logic [SCAN_LEN-1:0] pend_d, val_d;
	logic [2:0]         off_q;
	chan_t              chn_q;
	logic               slot_free;
	logic               sym_valid_q;
	logic [6:0]         char_q;
	logic               last_q;
	logic               adv;

	// Frame capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vel_q <= palm_vertical_velocity;
			pitch_q <= palm_pitch;
			yaw_q <= palm_yaw;
		end
	end

	// Magnitude of velocity times reciprocal of 100
	assign vneg = -{vel_q[15], vel_q};
	assign vmag = vel_q[15] ? vneg[15:0] : vel_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= vmag * DIV_MUL;
			vneg_s1 <= vel_q[15];
		end
	end

	// Throttle: add truncated quotient, clamp to 0..127
	assign quot = prod_s1[31:DIV_SHIFT];
	assign squot = vneg_s1 ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
	assign tsum = signed'({4'd0, thr_q}) + squot;

	always_comb begin
		if (tsum < 0)
			new_t = 7'd0;
		else if (tsum > signed'({4'd0, THR_MAX}))
			new_t = THR_MAX;
		else
			new_t = tsum[6:0];
	end

	// Pitch quantization on the negated angle
	assign pneg = -{pitch_q[15], pitch_q};

	always_comb begin
		if (pneg < PITCH_T1)
			new_p = PITCH_L1;
		else if (pneg < PITCH_T2)
			new_p = PITCH_L2;
		else if (pneg < PITCH_T3)
			new_p = PITCH_L3;
		else if (pneg < PITCH_T4)
			new_p = PITCH_L4;
		else if (pneg < PITCH_T5)
			new_p = PITCH_L5;
		else
			new_p = pit_q;
	end

	// Yaw quantization
	always_comb begin
		if (yaw_q < YAW_LO)
			new_y = YAW_NEG;
		else if (yaw_q > YAW_HI)
			new_y = YAW_POS;
		else
			new_y = YAW_MID;
	end

	assign chg_t = thr_q ^ new_t;
	assign chg_p = pit_q ^ new_p;
	assign chg_y = yawl_q ^ new_y;

	// Scan vectors, MSB first: bit 6 throttle, pitch, yaw, then bit 5 ...
	always_comb begin
		for (int b = 0; b < LVL_W; b++) begin
			pend_d[NUM_CH*b + 2] = chg_t[b];
			pend_d[NUM_CH*b + 1] = chg_p[b];
			pend_d[NUM_CH*b]     = chg_y[b];
			val_d[NUM_CH*b + 2]  = new_t[b];
			val_d[NUM_CH*b + 1]  = new_p[b];
			val_d[NUM_CH*b]      = new_y[b];
		end
	end

	// Levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			pit_q <= '0;
			yawl_q <= '0;
		end else if (cmd.upd) begin
			thr_q <= new_t;
			pit_q <= new_p;
			yawl_q <= new_y;
		end
	end

	// Output slot can take a beat this cycle
	assign slot_free = !sym_valid_q || !sym_stall;
	assign adv = cmd.step && slot_free;

	// Change scan, one position per cycle while the output slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			off_q <= '0;
			chn_q <= CH_THR;
		end else if (cmd.upd) begin
			pend_q <= pend_d;
			off_q <= '0;
			chn_q <= CH_THR;
		end else if (adv) begin
			pend_q <= {pend_q[SCAN_LEN-2:0], 1'b0};
			if (chn_q == CH_YAW) begin
				chn_q <= CH_THR;
				off_q <= off_q + 3'd1;
			end else begin
				chn_q <= chan_t'(chn_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd)
			val_q <= val_d;
		else if (adv)
			val_q <= {val_q[SCAN_LEN-2:0], 1'b0};
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sym_valid_q <= 1'b0;
		else if (slot_free)
			sym_valid_q <= adv && pend_q[SCAN_LEN-1];
	end

	always_ff @(posedge clk) begin
		if (adv && pend_q[SCAN_LEN-1]) begin
			char_q <= sym_char(chn_q, val_q[SCAN_LEN-1], off_q);
			last_q <= ~|pend_q[SCAN_LEN-2:0];
		end
	end

	assign stat.pend_empty = ~|pend_q;
	assign sym_valid = sym_valid_q;
	assign char_code = char_q;
	assign last = last_q;

endmodule

// ----- rtl/hpbc_ctrl.sv -----
// Controller: sequences capture, multiply, update and symbol scan of a frame.
module hpbc_ctrl import hpbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     frame_valid,
	output logic     frame_stall,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		frame_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				frame_stall = 1'b0;
				if (frame_valid) begin
					cmd.load = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.pend_empty)
					state_d = ST_IDLE;
				else
					cmd.step = 1'b1;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/hand_pose_to_bit_change_symbols_unit.sv -----
// Top level of the hand pose to bit-change symbol unit.
//
// Frame channel (frame_valid / frame_stall): one beat carries velocity, pitch
// and yaw of a hand frame. Symbol channel (sym_valid / sym_stall): one beat
// per changed level bit, char_code names channel, bit and new value, last
// marks the final symbol of the frame. A frame with no changed bit gives no
// beat at all.
// After the frame beat is taken, the controller runs the multiply and the
// level update before the scan; the first symbol comes later for each scan
// position ahead of the first change.
// The scan walks the 21 bit positions (bit 6..0, throttle/pitch/yaw each)
// one per cycle while the output slot is free, and stops after the last
// pending change; frame_stall is high while a frame keeps the unit busy. The
// divide by 100 is one 16x16 multiply, registered before the level update.
// When the receiver stalls, the held symbol stays on the port and the scan
// waits; the next frame may be taken while the final symbol still waits.
// Reset clears all three levels to zero and empties the output register.
module hand_pose_to_bit_change_symbols_unit import hpbc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_valid,
	output logic               frame_stall,
	input  logic signed [15:0] palm_vertical_velocity,
	input  logic signed [15:0] palm_pitch,
	input  logic signed [15:0] palm_yaw,
	output logic               sym_valid,
	input  logic               sym_stall,
	output logic [6:0]         char_code,
	output logic               last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	hpbc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.cmd         (cmd),
		.stat        (stat)
	);

	hpbc_dp u_dp (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.stat                   (stat),
		.palm_vertical_velocity (palm_vertical_velocity),
		.palm_pitch             (palm_pitch),
		.palm_yaw               (palm_yaw),
		.sym_valid              (sym_valid),
		.sym_stall              (sym_stall),
		.char_code              (char_code),
		.last                   (last)
	);

endmodule

// ----- rtl/hpbc_checker.sv -----
// Port-level checks of the hand pose symbol unit, bound to its top level.
`include "assert_macros.svh"

module hpbc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       frame_valid,
	input logic       frame_stall,
	input logic       sym_valid,
	input logic       sym_stall,
	input logic [6:0] char_code,
	input logic       last
);

	// A held symbol beat keeps its payload
	`HPBC_ASSERT(a_sym_hold, clk, arst_n, sym_valid && sym_stall |=> sym_valid && $stable(char_code) && $stable(last))

	// A taken frame blocks the next one
	`HPBC_ASSERT(a_frame_busy, clk, arst_n, frame_valid && !frame_stall |=> frame_stall)

	// A new symbol only appears while a frame is being scanned
	`HPBC_ASSERT(a_sym_in_frame, clk, arst_n, $rose(sym_valid) |-> frame_stall)

	// Symbols lie in the letter ranges of the three channels
	`HPBC_ASSERT_ALWAYS(a_sym_range, clk, !sym_valid || (char_code >= 7'd66 && char_code <= 7'd88) || (char_code >= 7'd98 && char_code <= 7'd120))

endmodule

bind hand_pose_to_bit_change_symbols_unit hpbc_checker u_hpbc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.frame_valid (frame_valid),
	.frame_stall (frame_stall),
	.sym_valid   (sym_valid),
	.sym_stall   (sym_stall),
	.char_code   (char_code),
	.last        (last)
);

// ----- bench/hand_pose_to_bit_change_symbols_unit_test.sv -----
// Testbench for the hand pose to bit-change symbol unit: directed rows, then random frames.
module hand_pose_to_bit_change_symbols_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	// One symbol beat as seen on the output channel
	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} sym_beat_t;

	logic               clk;
	logic               arst_n;
	logic               frame_valid;
	logic               frame_stall;
	logic signed [15:0] palm_vertical_velocity;
	logic signed [15:0] palm_pitch;
	logic signed [15:0] palm_yaw;
	logic               sym_valid;
	logic               sym_stall = 1'b0;
	logic [6:0]         char_code;
	logic               last;

	// Predicted channel levels
	logic [6:0] thr_lvl;
	logic [6:0] pit_lvl;
	logic [6:0] yaw_lvl;

	// Symbols still owed by the unit, oldest first
	sym_beat_t pending_syms [$];

	// Symbols typed in by hand for the beat now on the frame port
	bit    cur_typed;
	string cur_syms;

	// Directed rows
	logic signed [15:0] row_vel [$];
	logic signed [15:0] row_pit [$];
	logic signed [15:0] row_yaw [$];
	bit                 row_typed [$];
	string              row_syms [$];

	int idle_pct;
	int stall_pct;
	int n_fail;
	int n_frames;
	int n_syms;

	hand_pose_to_bit_change_symbols_unit i_dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.frame_valid            (frame_valid),
		.frame_stall            (frame_stall),
		.palm_vertical_velocity (palm_vertical_velocity),
		.palm_pitch             (palm_pitch),
		.palm_yaw               (palm_yaw),
		.sym_valid              (sym_valid),
		.sym_stall              (sym_stall),
		.char_code              (char_code),
		.last                   (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on run length
	initial begin
		#20ms;
		$display("hand_pose_to_bit_change_symbols_unit_test NOT OK");
		$finish;
	end

	// Update the predicted levels from one frame; queue its symbols when keep is set
	function automatic void predict_frame(input logic signed [15:0] vel,
			input logic signed [15:0] pit, input logic signed [15:0] yw, input bit keep);
		int          thr_sum;
		int          neg_pit;
		int          yaw_i;
		logic [6:0]  nxt [3];
		logic [6:0]  cur [3];
		logic [6:0]  diff;
		byte unsigned on_base [3];
		byte unsigned off_base [3];
		sym_beat_t   frame_syms [$];
		sym_beat_t   beat;
		on_base = '{8'h52, 8'h4A, 8'h42};  // R J B
		off_base = '{8'h72, 8'h6A, 8'h62}; // r j b

		// throttle: truncating divide, clamp to 0..127
		thr_sum = int'(thr_lvl) + int'(vel) / 100;
		if (thr_sum > 127)
			thr_sum = 127;
		if (thr_sum < 0)
			thr_sum = 0;
		nxt[0] = 7'(thr_sum);

		// pitch bands on the negated angle, hold beyond the top band
		neg_pit = -int'(pit);
		if (neg_pit < 2212)
			nxt[1] = 7'd13;
		else if (neg_pit < 4424)
			nxt[1] = 7'd38;
		else if (neg_pit < 6636)
			nxt[1] = 7'd63;
		else if (neg_pit < 8848)
			nxt[1] = 7'd89;
		else if (neg_pit < 11060)
			nxt[1] = 7'd114;
		else
			nxt[1] = pit_lvl;

		// yaw dead band
		yaw_i = int'(yw);
		if (yaw_i >= -4096 && yaw_i <= 4096)
			nxt[2] = 7'd63;
		else if (yaw_i < -4096)
			nxt[2] = 7'd31;
		else
			nxt[2] = 7'd94;

		cur = '{thr_lvl, pit_lvl, yaw_lvl};

		// scan bit 6 down to 0, channels throttle, pitch, yaw
		for (int b = 6; b >= 0; b--) begin
			for (int c = 0; c < 3; c++) begin
				diff = cur[c] ^ nxt[c];
				if (diff[b]) begin
					beat.code = 7'((nxt[c][b] ? on_base[c] : off_base[c]) + (6 - b));
					beat.last = 1'b0;
					frame_syms.push_back(beat);
				end
			end
		end
		if (frame_syms.size() > 0)
			frame_syms[frame_syms.size() - 1].last = 1'b1;
		if (keep)
			foreach (frame_syms[i])
				pending_syms.push_back(frame_syms[i]);

		thr_lvl = nxt[0];
		pit_lvl = nxt[1];
		yaw_lvl = nxt[2];
	endfunction

	// Frame accept and symbol check
	always @(posedge clk) begin
		sym_beat_t want;
		if (arst_n && frame_valid && !frame_stall) begin
			n_frames++;
			if (cur_typed) begin
				predict_frame(palm_vertical_velocity, palm_pitch, palm_yaw, 1'b0);
				for (int i = 0; i < cur_syms.len(); i++) begin
					want.code = 7'(cur_syms[i]);
					want.last = (i == cur_syms.len() - 1);
					pending_syms.push_back(want);
				end
			end else begin
				predict_frame(palm_vertical_velocity, palm_pitch, palm_yaw, 1'b1);
			end
		end
		if (arst_n && sym_valid && !sym_stall) begin
			n_syms++;
			if (pending_syms.size() == 0) begin
				$error("symbol beat 0x%02h with nothing expected", char_code);
				n_fail++;
			end else begin
				want = pending_syms.pop_front();
				if (char_code !== want.code) begin
					$error("char_code expected 0x%02h got 0x%02h", want.code, char_code);
					n_fail++;
				end
				if (last !== want.last) begin
					$error("last expected %0b got %0b", want.last, last);
					n_fail++;
				end
			end
		end
	end

	// Receiver stall
	always @(negedge clk)
		sym_stall <= (int'($urandom_range(99)) < stall_pct);

	task automatic add_row(input logic signed [15:0] vel, input logic signed [15:0] pit,
			input logic signed [15:0] yw, input bit typed, input string syms);
		row_vel.push_back(vel);
		row_pit.push_back(pit);
		row_yaw.push_back(yw);
		row_typed.push_back(typed);
		row_syms.push_back(syms);
	endtask

	// Present one frame beat from a falling edge and hold it until taken
	task automatic send_frame(input logic signed [15:0] vel, input logic signed [15:0] pit,
			input logic signed [15:0] yw, input bit typed, input string syms);
		while (int'($urandom_range(99)) < idle_pct) begin
			frame_valid <= 1'b0;
			@(negedge clk);
		end
		frame_valid <= 1'b1;
		palm_vertical_velocity <= vel;
		palm_pitch <= pit;
		palm_yaw <= yw;
		cur_typed <= typed;
		cur_syms <= syms;
		@(posedge clk);
		while (frame_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_vel();
		int r;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: r = int'($urandom_range(6000)) - 3000;
			5, 6: r = (int'($urandom_range(60)) - 30) * 100 + int'($urandom_range(2)) - 1;
			7: r = ($urandom_range(1) != 0) ? 32767 - int'($urandom_range(200))
				: -32768 + int'($urandom_range(200));
			default: r = int'($urandom_range(65535)) - 32768;
		endcase
		return 16'(r);
	endfunction

	function automatic logic signed [15:0] rand_pitch();
		int bounds [6];
		int r;
		bounds = '{0, 2212, 4424, 6636, 8848, 11060};
		case ($urandom_range(9))
			0, 1, 2, 3: r = -(bounds[$urandom_range(5)] + int'($urandom_range(4)) - 2);
			4, 5, 6: r = -int'($urandom_range(12000));
			7: r = -(11060 + int'($urandom_range(21707)));
			default: r = int'($urandom_range(65535)) - 32768;
		endcase
		return 16'(r);
	endfunction

	function automatic logic signed [15:0] rand_yaw();
		int r;
		case ($urandom_range(9))
			0, 1, 2, 3: r = (($urandom_range(1) != 0) ? 4096 : -4096) + int'($urandom_range(6)) - 3;
			4, 5, 6: r = int'($urandom_range(16384)) - 8192;
			default: r = int'($urandom_range(65535)) - 32768;
		endcase
		return 16'(r);
	endfunction

	initial begin
		int idle_set [4];
		int stall_set [4];
		idle_set = '{0, 62, 0, 11};
		stall_set = '{0, 0, 62, 11};

		arst_n = 1'b0;
		frame_valid = 1'b0;
		palm_vertical_velocity = '0;
		palm_pitch = '0;
		palm_yaw = '0;
		cur_typed = 1'b0;
		cur_syms = "";
		thr_lvl = '0;
		pit_lvl = '0;
		yaw_lvl = '0;
		idle_pct = 0;
		stall_pct = 0;
		n_fail = 0;
		n_frames = 0;
		n_syms = 0;

		// Directed rows: typed symbols where the answer is plain, predictor elsewhere
		add_row(16'sd0, 16'sd0, 16'sd0, 1'b1, "CDMENFGPH");    // first frame after reset
		add_row(16'sd0, 16'sd0, 16'sd0, 1'b1, "");             // nothing changed
		add_row(16'sd32767, 16'sd0, 16'sd0, 1'b1, "RSTUVWX");  // throttle to top
		add_row(16'sd32767, 16'sd0, 16'sd0, 1'b1, "");         // held at top
		add_row(-16'sd32768, 16'sd0, 16'sd0, 1'b1, "rstuvwx"); // throttle to zero
		add_row(-16'sd32768, 16'sd0, 16'sd0, 1'b1, "");        // held at zero
		add_row(16'sd0, -16'sd32768, 16'sd0, 1'b1, "");        // pitch past top band holds
		add_row(16'sd0, -16'sd11059, 16'sd0, 1'b0, "");
		add_row(16'sd0, -16'sd11060, 16'sd0, 1'b0, "");
		add_row(16'sd0, -16'sd8848, -16'sd4097, 1'b0, "");
		add_row(16'sd0, -16'sd8847, 16'sd4097, 1'b0, "");
		add_row(16'sd0, -16'sd6636, -16'sd4096, 1'b0, "");
		add_row(16'sd0, -16'sd6635, 16'sd4096, 1'b0, "");
		add_row(16'sd0, -16'sd4424, 16'sd32767, 1'b0, "");
		add_row(16'sd0, -16'sd4423, -16'sd32768, 1'b0, "");
		add_row(16'sd0, -16'sd2212, 16'sd0, 1'b0, "");
		add_row(16'sd0, -16'sd2211, 16'sd0, 1'b0, "");
		add_row(16'sd0, 16'sd32767, 16'sd0, 1'b0, "");
		add_row(16'sd99, 16'sd0, 16'sd0, 1'b0, "");
		add_row(16'sd100, 16'sd0, 16'sd0, 1'b0, "");
		add_row(16'sd12700, 16'sd0, 16'sd0, 1'b0, "");
		add_row(-16'sd99, 16'sd0, 16'sd0, 1'b0, "");
		add_row(-16'sd100, 16'sd0, 16'sd0, 1'b0, "");
		add_row(16'sd5555, -16'sd9999, -16'sd5000, 1'b0, "");
		add_row(-16'sd1, -16'sd1, -16'sd1, 1'b0, "");

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (row_vel[i])
			send_frame(row_vel[i], row_pit[i], row_yaw[i], row_typed[i], row_syms[i]);

		// Random frames under each pressure setting
		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			repeat (40)
				send_frame(rand_vel(), rand_pitch(), rand_yaw(), 1'b0, "");
		end
		frame_valid <= 1'b0;
		stall_pct = 0;

		while (pending_syms.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Ran %0d hand frames under four idle/stall mixes, %0d symbol beats compared.",
			n_frames, n_syms);
		if (n_fail == 0) begin
			$display("hand_pose_to_bit_change_symbols_unit_test OK");
		end else begin
			$display("hand_pose_to_bit_change_symbols_unit_test NOT OK");
		end
		$finish;
	end

endmodule
